// File: hdl/fbga_pkg.sv
// Shared types and constants of the fragmenting best-fit gap allocator.
package fbga_pkg;

  localparam int ADDR_W      = 32;
  localparam int MAX_EXTENTS = 256;
  localparam int EXT_IDX_W   = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int GAP_DEPTH   = MAX_EXTENTS + 1;
  localparam int GAP_IDX_W   = $clog2(GAP_DEPTH + 1);
  localparam int MAX_FRAGS   = 8;
  localparam int FRAG_IDX_W  = $clog2(MAX_FRAGS);
  localparam int DELIM_W     = 8;
  localparam int MAXF_W      = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CATALOG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXF    = 2'd3;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_ALLOC = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_FRAG = 2'd0,
    ST_ACK  = 2'd1,
    ST_FAIL = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] extent_offset;
    logic [ADDR_W-1:0] extent_bytes;
    logic [ADDR_W-1:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [ADDR_W-1:0]     fragment_offset;
    logic [ADDR_W-1:0]     fragment_bytes;
    logic [FRAG_IDX_W-1:0] fragment_index;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic                 prev_valid;
    logic [ADDR_W-1:0]    prev_off;
    logic [EXT_IDX_W-1:0] prev_idx;
  } ext_req_t;

  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [ADDR_W-1:0]    off;
    logic [ADDR_W-1:0]    len;
    logic [EXT_IDX_W-1:0] idx;
  } ext_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [GAP_IDX_W-1:0] ngaps;
    logic                 thr_valid;
    logic [ADDR_W-1:0]    thr_len;
    logic [GAP_IDX_W-1:0] thr_idx;
    logic [ADDR_W-1:0]    remaining;
    logic [ADDR_W-1:0]    delim;
  } gap_req_t;

  typedef struct packed {
    logic                 done;
    logic                 fit_found;
    logic [ADDR_W-1:0]    fit_start;
    logic                 big_found;
    logic [ADDR_W-1:0]    big_start;
    logic [ADDR_W-1:0]    big_len;
    logic [GAP_IDX_W-1:0] big_idx;
  } gap_rsp_t;

endpackage

// File: hdl/fragmenting_best_fit_gap_allocator.sv
// Top level: one item at a time; clear and add beats answer in the cycle after acceptance.
// An allocate with n stored extents walks the extent memory in offset order in n+1 passes,
// then makes up to max_fragments passes over the gap memory (zero counts as one, and
// values above MAX_FRAGS count as MAX_FRAGS).
// Results leave through one output register. Synchronous reset clears the extent count,
// the control state and the output, and loads the register defaults; memories are not cleared.
module fragmenting_best_fit_gap_allocator import fbga_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXT  = 5'b00010,
    S_GAP  = 5'b00100,
    S_EMIT = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     total_r;
  logic [ADDR_W-1:0]     catalog_r;
  logic [DELIM_W-1:0]    delim_r;
  logic [MAXF_W-1:0]     maxf_r;
  logic [ADDR_W:0]       pend_r;
  logic                  prev_vld_r;
  logic [ADDR_W-1:0]     prev_off_r;
  logic [EXT_IDX_W-1:0]  prev_idx_r;
  logic [GAP_IDX_W-1:0]  gidx_r;
  logic [GAP_IDX_W-1:0]  ngaps_r;
  logic [ADDR_W-1:0]     remaining_r;
  logic                  thr_vld_r;
  logic [ADDR_W-1:0]     thr_len_r;
  logic [GAP_IDX_W-1:0]  thr_idx_r;
  logic [FRAG_IDX_W-1:0] frag_i_r;
  logic [FRAG_IDX_W-1:0] frag_last_r;
  logic [FRAG_IDX_W-1:0] emit_i_r;
  logic [ADDR_W-1:0]     frag_off_r [MAX_FRAGS];
  logic [ADDR_W-1:0]     frag_len_r [MAX_FRAGS];
  logic                  out_valid_r;
  out_item_t             out_data_r;

  ext_req_t              ext_req;
  ext_rsp_t              ext_rsp;
  gap_req_t              gap_req;
  gap_rsp_t              gap_rsp;
  logic                  ext_full;
  logic                  ext_clr;
  logic                  ext_wr;
  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  out_item_t             out_nxt;
  logic [ADDR_W-1:0]     delim_w;
  logic [ADDR_W:0]       gap_end;
  logic [ADDR_W:0]       gap_len;
  logic                  gap_wr;
  logic [FRAG_IDX_W-1:0] lim_last;
  logic                  ext_pass_done;
  logic                  gap_pass_done;
  logic                  gap_fail;
  logic                  gap_more;
  logic                  emit_last;

  assign delim_w  = {{(ADDR_W-DELIM_W){1'b0}}, delim_r};
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign lim_last = (maxf_r == '0) ? '0 :
                    (maxf_r >= MAXF_W'(MAX_FRAGS)) ? FRAG_IDX_W'(MAX_FRAGS - 1) :
                    FRAG_IDX_W'(maxf_r - 1'b1);

  assign ext_pass_done = (state_r == S_EXT) && ext_rsp.done;
  assign gap_pass_done = (state_r == S_GAP) && gap_rsp.done;
  assign gap_fail      = !gap_rsp.fit_found &&
                         ((frag_i_r == lim_last) || !gap_rsp.big_found ||
                          (gap_rsp.big_len <= delim_w));
  assign gap_more      = gap_pass_done && !gap_rsp.fit_found && !gap_fail;
  assign emit_last     = (emit_i_r == frag_last_r);

  assign gap_end = ext_rsp.found ? {1'b0, ext_rsp.off} : {1'b0, total_r};
  assign gap_len = (gap_end > pend_r) ? (gap_end - pend_r) : '0;
  assign gap_wr  = ext_pass_done;

  assign ext_clr = in_acc && (in_data.func == FUNC_CLEAR);
  assign ext_wr  = in_acc && (in_data.func == FUNC_ADD) && !ext_full;

  assign ext_req.start      = (in_acc && (in_data.func == FUNC_ALLOC)) ||
                              (ext_pass_done && ext_rsp.found);
  assign ext_req.prev_valid = prev_vld_r;
  assign ext_req.prev_off   = prev_off_r;
  assign ext_req.prev_idx   = prev_idx_r;

  assign gap_req.start     = (ext_pass_done && !ext_rsp.found) || gap_more;
  assign gap_req.ngaps     = ngaps_r;
  assign gap_req.thr_valid = thr_vld_r;
  assign gap_req.thr_len   = thr_len_r;
  assign gap_req.thr_idx   = thr_idx_r;
  assign gap_req.remaining = remaining_r;
  assign gap_req.delim     = delim_w;

  fbga_ext_tbl u_ext (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (ext_clr),
    .wr     (ext_wr),
    .wr_off (in_data.extent_offset),
    .wr_len (in_data.extent_bytes),
    .full   (ext_full),
    .req    (ext_req),
    .rsp    (ext_rsp)
  );

  fbga_gap_tbl u_gap (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (gap_wr),
    .wr_idx   (gidx_r),
    .wr_start (pend_r[ADDR_W-1:0]),
    .wr_len   (gap_len[ADDR_W-1:0]),
    .req      (gap_req),
    .rsp      (gap_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    out_nxt   = '{status: ST_ACK, fragment_offset: '0, fragment_bytes: '0,
                  fragment_index: '0, last: 1'b1};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.func)
            FUNC_CLEAR: begin
              out_load = 1'b1;
            end
            FUNC_ADD: begin
              out_load = 1'b1;
              if (ext_full) begin
                out_nxt.status = ST_FULL;
              end
            end
            FUNC_ALLOC: begin
              state_nxt = S_EXT;
            end
            FUNC_NONE: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EXT: begin
        if (ext_pass_done && !ext_rsp.found) begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        if (gap_pass_done) begin
          if (gap_rsp.fit_found) begin
            state_nxt = S_EMIT;
          end else if (gap_fail) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '{status: ST_FRAG, fragment_offset: frag_off_r[emit_i_r],
                       fragment_bytes: frag_len_r[emit_i_r], fragment_index: emit_i_r,
                       last: emit_last};
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_nxt.status = ST_FAIL;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      catalog_r   <= '0;
      delim_r     <= DELIM_W'(2);
      maxf_r      <= MAXF_W'(MAX_FRAGS);
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_TOTAL:   total_r   <= cfg_wdata;
          CFG_CATALOG: catalog_r <= cfg_wdata;
          CFG_DELIM:   delim_r   <= cfg_wdata[DELIM_W-1:0];
          CFG_MAXF:    maxf_r    <= cfg_wdata[MAXF_W-1:0];
          default:     maxf_r    <= maxf_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
    if (in_acc && (in_data.func == FUNC_ALLOC)) begin
      pend_r      <= {1'b0, catalog_r};
      prev_vld_r  <= 1'b0;
      gidx_r      <= '0;
      remaining_r <= in_data.request_bytes;
      thr_vld_r   <= 1'b0;
      frag_i_r    <= '0;
    end
    if (ext_pass_done) begin
      gidx_r <= gidx_r + 1'b1;
      if (ext_rsp.found) begin
        pend_r     <= {1'b0, ext_rsp.off} + {1'b0, ext_rsp.len};
        prev_vld_r <= 1'b1;
        prev_off_r <= ext_rsp.off;
        prev_idx_r <= ext_rsp.idx;
      end else begin
        ngaps_r <= gidx_r + 1'b1;
      end
    end
    if (gap_pass_done && gap_rsp.fit_found) begin
      frag_off_r[frag_i_r] <= gap_rsp.fit_start;
      frag_len_r[frag_i_r] <= remaining_r + delim_w;
      frag_last_r          <= frag_i_r;
      emit_i_r             <= '0;
    end
    if (gap_more) begin
      frag_off_r[frag_i_r] <= gap_rsp.big_start;
      frag_len_r[frag_i_r] <= gap_rsp.big_len;
      remaining_r          <= remaining_r - (gap_rsp.big_len - delim_w);
      thr_vld_r            <= 1'b1;
      thr_len_r            <= gap_rsp.big_len;
      thr_idx_r            <= gap_rsp.big_idx;
      frag_i_r             <= frag_i_r + 1'b1;
    end
    if ((state_r == S_EMIT) && out_free && !emit_last) begin
      emit_i_r <= emit_i_r + 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/fbga_ext_tbl.sv
// Used-extent memory with a pass that finds the next extent in offset order.
module fbga_ext_tbl import fbga_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              wr,
  input  logic [ADDR_W-1:0] wr_off,
  input  logic [ADDR_W-1:0] wr_len,
  output logic              full,
  input  ext_req_t          req,
  output ext_rsp_t          rsp
);

  logic [2*ADDR_W-1:0]  mem [MAX_EXTENTS];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     addr_r;
  logic                 run_r;
  logic                 rd_vld_r;
  logic [EXT_IDX_W-1:0] rd_idx_r;
  logic [2*ADDR_W-1:0]  rd_q_r;
  logic                 best_vld_r;
  logic [ADDR_W-1:0]    best_off_r;
  logic [ADDR_W-1:0]    best_len_r;
  logic [EXT_IDX_W-1:0] best_idx_r;
  logic                 issue;
  logic                 done;
  logic [ADDR_W-1:0]    rd_off;
  logic [ADDR_W-1:0]    rd_len;
  logic                 above;
  logic                 take;

  assign issue  = run_r && (addr_r < count_r);
  assign done   = run_r && !issue && !rd_vld_r;
  assign rd_off = rd_q_r[2*ADDR_W-1:ADDR_W];
  assign rd_len = rd_q_r[ADDR_W-1:0];
  assign above  = !req.prev_valid || (rd_off > req.prev_off) ||
                  ((rd_off == req.prev_off) && (rd_idx_r > req.prev_idx));
  assign take   = rd_vld_r && above && (!best_vld_r || (rd_off < best_off_r));
  assign full   = (count_r == CNT_W'(MAX_EXTENTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      addr_r     <= '0;
      run_r      <= 1'b0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        count_r <= '0;
      end else if (wr) begin
        count_r <= count_r + 1'b1;
      end
      rd_vld_r <= issue;
      if (req.start) begin
        run_r      <= 1'b1;
        addr_r     <= '0;
        best_vld_r <= 1'b0;
      end else begin
        if (done) begin
          run_r <= 1'b0;
        end else if (issue) begin
          addr_r <= addr_r + 1'b1;
        end
        if (take) begin
          best_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[count_r[EXT_IDX_W-1:0]] <= {wr_off, wr_len};
    end
    if (issue) begin
      rd_q_r <= mem[addr_r[EXT_IDX_W-1:0]];
    end
    rd_idx_r <= addr_r[EXT_IDX_W-1:0];
    if (take) begin
      best_off_r <= rd_off;
      best_len_r <= rd_len;
      best_idx_r <= rd_idx_r;
    end
  end

  assign rsp.done  = done;
  assign rsp.found = best_vld_r;
  assign rsp.off   = best_off_r;
  assign rsp.len   = best_len_r;
  assign rsp.idx   = best_idx_r;

endmodule

// File: hdl/fbga_gap_tbl.sv
// Free-gap memory with a pass that finds the best-fit gap and the largest unused gap.
module fbga_gap_tbl import fbga_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  logic [GAP_IDX_W-1:0] wr_idx,
  input  logic [ADDR_W-1:0]    wr_start,
  input  logic [ADDR_W-1:0]    wr_len,
  input  gap_req_t             req,
  output gap_rsp_t             rsp
);

  logic [2*ADDR_W-1:0]  mem [GAP_DEPTH];
  logic [GAP_IDX_W-1:0] addr_r;
  logic                 run_r;
  logic                 rd_vld_r;
  logic [GAP_IDX_W-1:0] rd_idx_r;
  logic [2*ADDR_W-1:0]  rd_q_r;
  logic                 fit_vld_r;
  logic [ADDR_W-1:0]    fit_len_r;
  logic [ADDR_W-1:0]    fit_start_r;
  logic                 big_vld_r;
  logic [ADDR_W-1:0]    big_len_r;
  logic [ADDR_W-1:0]    big_start_r;
  logic [GAP_IDX_W-1:0] big_idx_r;
  logic                 issue;
  logic                 done;
  logic [ADDR_W-1:0]    rd_start;
  logic [ADDR_W-1:0]    rd_len;
  logic                 unused;
  logic                 fits;
  logic                 take_fit;
  logic                 take_big;

  assign issue    = run_r && (addr_r < req.ngaps);
  assign done     = run_r && !issue && !rd_vld_r;
  assign rd_start = rd_q_r[2*ADDR_W-1:ADDR_W];
  assign rd_len   = rd_q_r[ADDR_W-1:0];
  assign unused   = !req.thr_valid || (rd_len < req.thr_len) ||
                    ((rd_len == req.thr_len) && (rd_idx_r < req.thr_idx));
  assign fits     = (rd_len > req.delim) && (req.remaining <= (rd_len - req.delim));
  assign take_fit = rd_vld_r && unused && fits && (!fit_vld_r || (rd_len < fit_len_r));
  assign take_big = rd_vld_r && unused && (!big_vld_r || (rd_len >= big_len_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      run_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      fit_vld_r <= 1'b0;
      big_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (req.start) begin
        run_r     <= 1'b1;
        addr_r    <= '0;
        fit_vld_r <= 1'b0;
        big_vld_r <= 1'b0;
      end else begin
        if (done) begin
          run_r <= 1'b0;
        end else if (issue) begin
          addr_r <= addr_r + 1'b1;
        end
        if (take_fit) begin
          fit_vld_r <= 1'b1;
        end
        if (take_big) begin
          big_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_idx] <= {wr_start, wr_len};
    end
    if (issue) begin
      rd_q_r <= mem[addr_r];
    end
    rd_idx_r <= addr_r;
    if (take_fit) begin
      fit_len_r   <= rd_len;
      fit_start_r <= rd_start;
    end
    if (take_big) begin
      big_len_r   <= rd_len;
      big_start_r <= rd_start;
      big_idx_r   <= rd_idx_r;
    end
  end

  assign rsp.done      = done;
  assign rsp.fit_found = fit_vld_r;
  assign rsp.fit_start = fit_start_r;
  assign rsp.big_found = big_vld_r;
  assign rsp.big_start = big_start_r;
  assign rsp.big_len   = big_len_r;
  assign rsp.big_idx   = big_idx_r;

endmodule

// File: tb/tb.sv
// Testbench for the fragmenting best-fit gap allocator: random and directed beats, self-checking.
`timescale 1ns / 1ps
module tb;
  import fbga_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  fragmenting_best_fit_gap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  beat_q[$];
  out_item_t expected_q[$];
  int errors = 0;
  int stuck = 0;
  logic in_taken = 1'b0;
  bit quiet = 1'b0;

  logic [63:0] m_total, m_catalog;
  int unsigned m_delim, m_maxf;
  logic [63:0] ext_off[MAX_EXTENTS];
  logic [63:0] ext_len[MAX_EXTENTS];
  int ext_n;

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 34);
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void post(status_t st, logic [63:0] off, logic [63:0] len, int idx, bit lst);
    out_item_t r;
    r.status = st;
    r.fragment_offset = off[31:0];
    r.fragment_bytes = len[31:0];
    r.fragment_index = idx[FRAG_IDX_W-1:0];
    r.last = lst;
    expected_q.push_back(r);
  endfunction

  function automatic void place_request(logic [63:0] request);
    int eo[MAX_EXTENTS];
    int go[GAP_DEPTH];
    logic [63:0] gs[GAP_DEPTH];
    logic [63:0] gl[GAP_DEPTH];
    logic [63:0] fo[MAX_FRAGS];
    logic [63:0] fl[MAX_FRAGS];
    logic [63:0] pend, nxt, remaining, delim;
    int n, gaps, i, j, t, g, scan, limit, count;
    bit ok, stop;
    n = ext_n;
    for (i = 0; i < n; i++) eo[i] = i;
    for (i = 1; i < n; i++)
      for (j = i; j >= 1 && ext_off[eo[j]] < ext_off[eo[j-1]]; j--) begin
        t = eo[j]; eo[j] = eo[j-1]; eo[j-1] = t;
      end
    gs[0] = m_catalog;
    if (n == 0) gl[0] = (m_total > m_catalog) ? m_total - m_catalog : 64'd0;
    else gl[0] = (ext_off[eo[0]] > m_catalog) ? ext_off[eo[0]] - m_catalog : 64'd0;
    for (i = 1; i <= n; i++) begin
      pend = ext_off[eo[i-1]] + ext_len[eo[i-1]];
      nxt = (i < n) ? ext_off[eo[i]] : m_total;
      gs[i] = pend;
      gl[i] = (nxt > pend) ? nxt - pend : 64'd0;
    end
    gaps = n + 1;
    for (i = 0; i < gaps; i++) go[i] = i;
    for (i = 1; i < gaps; i++)
      for (j = i; j >= 1 && gl[go[j]] < gl[go[j-1]]; j--) begin
        t = go[j]; go[j] = go[j-1]; go[j-1] = t;
      end
    limit = (m_maxf == 0) ? 1 : ((m_maxf > MAX_FRAGS) ? MAX_FRAGS : m_maxf);
    remaining = request;
    delim = m_delim;
    ok = 1'b0;
    stop = 1'b0;
    count = 0;
    scan = gaps;
    for (i = 0; i < limit && !ok && !stop; i++) begin
      for (j = 0; j < scan && !ok; j++) begin
        g = go[j];
        if (gl[g] > delim && remaining <= gl[g] - delim) begin
          fo[i] = gs[g];
          fl[i] = remaining + delim;
          count = i + 1;
          ok = 1'b1;
        end
      end
      if (!ok) begin
        if (i == limit - 1 || scan == 0) stop = 1'b1;
        else begin
          g = go[scan-1];
          if (gl[g] <= delim) stop = 1'b1;
          else begin
            fo[i] = gs[g];
            fl[i] = gl[g];
            remaining = remaining - (gl[g] - delim);
            scan--;
          end
        end
      end
    end
    if (!ok) post(ST_FAIL, 0, 0, 0, 1'b1);
    else for (i = 0; i < count; i++) post(ST_FRAG, fo[i], fl[i], i, i + 1 == count);
  endfunction

  function automatic void predict(in_item_t it);
    case (it.func)
      FUNC_CLEAR: begin
        ext_n = 0;
        post(ST_ACK, 0, 0, 0, 1'b1);
      end
      FUNC_ADD: begin
        if (ext_n >= MAX_EXTENTS) post(ST_FULL, 0, 0, 0, 1'b1);
        else begin
          ext_off[ext_n] = {32'd0, it.extent_offset};
          ext_len[ext_n] = {32'd0, it.extent_bytes};
          ext_n++;
          post(ST_ACK, 0, 0, 0, 1'b1);
        end
      end
      FUNC_ALLOC: place_request({32'd0, it.request_bytes});
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      m_total <= 64'd0; m_catalog <= 64'd0; m_delim <= 2; m_maxf <= 8; ext_n <= 0;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_TOTAL:   m_total <= {32'd0, cfg_wdata};
          CFG_CATALOG: m_catalog <= {32'd0, cfg_wdata};
          CFG_DELIM:   m_delim <= cfg_wdata[DELIM_W-1:0];
          default:     m_maxf <= cfg_wdata[MAXF_W-1:0];
        endcase
      end
      if (in_valid && !in_stall) predict(in_data);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) report("result with nothing expected");
        else begin
          w = expected_q.pop_front();
          if (out_data.status !== w.status) report("status");
          if (out_data.fragment_offset !== w.fragment_offset) report("fragment_offset");
          if (out_data.fragment_bytes !== w.fragment_bytes) report("fragment_bytes");
          if (out_data.fragment_index !== w.fragment_index) report("fragment_index");
          if (out_data.last !== w.last) report("last");
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck >= 300000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= idle_now();
      if (!in_valid || in_taken) begin
        if (beat_q.size() != 0 && !idle_now()) begin
          in_valid <= 1'b1;
          in_data <= beat_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic send(func_t f, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    in_item_t it;
    it.func = f;
    it.extent_offset = a;
    it.extent_bytes = b;
    it.request_bytes = c;
    beat_q.push_back(it);
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_total();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(200, 100000);
    endcase
  endfunction

  initial begin
    int sent, k, m, i;
    logic [31:0] tot;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(FUNC_ALLOC, 0, 0, 32'd5);
    send(FUNC_NONE, $urandom, $urandom, $urandom);
    write_reg(CFG_TOTAL, 32'd1000);
    write_reg(CFG_CATALOG, 32'd100);
    send(FUNC_ALLOC, 0, 0, 32'd0);
    send(FUNC_ALLOC, 0, 0, 32'd898);
    send(FUNC_ALLOC, 0, 0, 32'd899);
    send(FUNC_ADD, 32'd500, 32'd100, 0);
    send(FUNC_ADD, 32'd300, 32'd250, 0);
    send(FUNC_ADD, 32'd50, 32'd20, 0);
    send(FUNC_ADD, 32'hFFFF_FF00, 32'h0000_0200, 0);
    send(FUNC_ALLOC, 0, 0, 32'd150);
    send(FUNC_ALLOC, 0, 0, 32'd500);
    send(FUNC_ALLOC, 0, 0, 32'hFFFF_FFFF);
    write_reg(CFG_MAXF, 32'd1);
    send(FUNC_ALLOC, 0, 0, 32'd500);
    write_reg(CFG_MAXF, 32'd0);
    send(FUNC_ALLOC, 0, 0, 32'd300);
    write_reg(CFG_MAXF, 32'd15);
    send(FUNC_ALLOC, 0, 0, 32'd500);
    write_reg(CFG_DELIM, 32'd255);
    send(FUNC_ALLOC, 0, 0, 32'd10);
    write_reg(CFG_DELIM, 32'd0);
    send(FUNC_ALLOC, 0, 0, 32'd400);
    write_reg(CFG_CATALOG, 32'hFFFF_FFFF);
    send(FUNC_ALLOC, 0, 0, 32'd1);
    send(FUNC_CLEAR, $urandom, $urandom, $urandom);
    send(FUNC_ALLOC, 0, 0, 32'd1);

    write_reg(CFG_CATALOG, 32'd0);
    write_reg(CFG_TOTAL, 32'd100000);
    write_reg(CFG_DELIM, 32'd2);
    write_reg(CFG_MAXF, 32'd8);
    for (i = 0; i < MAX_EXTENTS; i++) send(FUNC_ADD, i * 390, $urandom_range(100, 389), 0);
    send(FUNC_ADD, $urandom, $urandom, 0);
    send(FUNC_ALLOC, 0, 0, 32'd1000);
    send(FUNC_CLEAR, 0, 0, 0);

    sent = 0;
    while (sent < 80) begin
      quiet = ($urandom_range(7) == 0);
      if ($urandom_range(1)) write_reg(CFG_TOTAL, pick_total());
      if ($urandom_range(1)) write_reg(CFG_CATALOG,
          $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 300));
      if ($urandom_range(1)) write_reg(CFG_DELIM,
          $urandom_range(3) == 0 ? ($urandom_range(1) ? 255 : 0) : $urandom_range(0, 20));
      if ($urandom_range(1)) write_reg(CFG_MAXF, $urandom_range(0, 15));
      tot = m_total[31:0];
      send(FUNC_CLEAR, $urandom, $urandom, $urandom);
      k = $urandom_range(0, 12);
      m = $urandom_range(2, 8);
      for (i = 0; i < k; i++) begin
        if ($urandom_range(9) == 0) send(FUNC_ADD, $urandom, $urandom, $urandom);
        else send(FUNC_ADD, $urandom_range(0, tot), $urandom_range(0, tot / 8), $urandom);
      end
      for (i = 0; i < m; i++) begin
        case ($urandom_range(5))
          0: send(FUNC_ALLOC, $urandom, $urandom, $urandom);
          1: send(FUNC_ALLOC, 0, 0, $urandom_range(0, 40));
          2: send(FUNC_NONE, $urandom, $urandom, $urandom);
          default: send(FUNC_ALLOC, 0, 0, $urandom_range(0, tot));
        endcase
      end
      sent += 1 + k + m;
      drain();
      quiet = 1'b0;
    end

    drain();
    repeat (200) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/fbga_pkg.sv
hdl/fbga_ext_tbl.sv
hdl/fbga_gap_tbl.sv
hdl/fragmenting_best_fit_gap_allocator.sv
tb/tb.sv
